// ----- design/triangle_scanline_span_assert.svh -----
// assertion macros for the triangle scanline span block
// used by the checker, relies on clk and rst_n in the enclosing scope
`ifndef TRIANGLE_SCANLINE_SPAN_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_ASSERT_SVH

// antecedent implies consequent, disabled in reset
`define TSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tss: implication check failed");

// expression must never hold outside reset
`define TSS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tss: forbidden condition seen");

`endif

// ----- design/tss_pkg.sv -----
// shared types and constants of the triangle scanline span block
// no dependencies
package tss_pkg;

  localparam int COORD_BITS = 12;
  localparam int XW         = COORD_BITS + 1;
  localparam int PW         = 2 * COORD_BITS + 2;
  localparam int NW         = 2 * COORD_BITS + 3;
  localparam int DW         = COORD_BITS + 2;
  localparam int QB         = COORD_BITS;
  localparam int CFG_W      = 11;
  localparam int IDX_W      = 3;
  localparam int SW         = ((XW > CFG_W + 1) ? XW : CFG_W + 1) + 1;
  localparam int SETUP_LAT  = 2;
  localparam int SPAN_LAT   = 4;
  localparam int LATENCY    = 1 + SETUP_LAT + QB + SPAN_LAT;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [XW-1:0]         xval_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CLIP_LEFT    = 3'd0,
    REG_CLIP_TOP     = 3'd1,
    REG_CLIP_RIGHT   = 3'd2,
    REG_CLIP_BOTTOM  = 3'd3,
    REG_CANVAS_WIDTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    coord_t      ax;
    coord_t      ay;
    coord_t      bx;
    coord_t      by;
    coord_t      cx;
    coord_t      cy;
    coord_t      row;
    logic [15:0] color_in;
  } in_item_t;

  typedef struct packed {
    logic        span_valid;
    logic [9:0]  span_row;
    logic [9:0]  first_column;
    logic [10:0] pixel_count;
    logic [20:0] byte_address;
    logic [15:0] color_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] clip_left;
    logic [CFG_W-1:0] clip_top;
    logic [CFG_W-1:0] clip_right;
    logic [CFG_W-1:0] clip_bottom;
    logic [CFG_W-1:0] canvas_width;
  } clip_cfg_t;

  typedef struct packed {
    logic  touch;
    logic  horiz;
    logic  neg;
    xval_t hlo;
    xval_t hhi;
  } edge_info_t;

  typedef struct packed {
    logic        valid;
    coord_t      row;
    logic [15:0] color;
  } side_t;

endpackage

// ----- design/tss_edge.sv -----
// edge setup: crossing numerator and denominator for one triangle edge
// depends on tss_pkg
module tss_edge (
  input  logic                         clk,
  input  tss_pkg::coord_t              ex0,
  input  tss_pkg::coord_t              ey0,
  input  tss_pkg::coord_t              ex1,
  input  tss_pkg::coord_t              ey1,
  input  tss_pkg::coord_t              y,
  output logic [tss_pkg::NW-1:0]       n_o,
  output logic [tss_pkg::DW-1:0]       d_o,
  output tss_pkg::edge_info_t          info_o
);
  import tss_pkg::*;

  logic signed [XW-1:0] den, dx, dy;
  logic signed [PW-1:0] p1_nxt, p2_nxt, p1_r, p2_r;
  logic signed [XW-1:0] den_r;
  logic                 touch_nxt, touch_r, horiz_r;
  xval_t                hlo_nxt, hhi_nxt, hlo_r, hhi_r;

  logic signed [NW-1:0] num;
  logic [NW-1:0]        anum;
  logic [XW-1:0]        aden;
  logic [NW-1:0]        n_nxt, n_r;
  logic [DW-1:0]        d_nxt, d_r;
  edge_info_t           info_nxt, info_r;

  // stage 1: products
  always_comb begin
    den       = XW'(ey1) - XW'(ey0);
    dx        = XW'(ex1) - XW'(ex0);
    dy        = XW'(y) - XW'(ey0);
    p1_nxt    = PW'(ex0) * PW'(den);
    p2_nxt    = PW'(dx) * PW'(dy);
    touch_nxt = !(((y < ey0) && (y < ey1)) || ((y > ey0) && (y > ey1)));
    hlo_nxt   = (ex0 < ex1) ? XW'(ex0) : XW'(ex1);
    hhi_nxt   = (ex0 < ex1) ? XW'(ex1) : XW'(ex0);
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    den_r   <= den;
    touch_r <= touch_nxt;
    horiz_r <= (ey0 == ey1);
    hlo_r   <= hlo_nxt;
    hhi_r   <= hhi_nxt;
  end

  // stage 2: rounding-biased magnitudes for the divider
  always_comb begin
    num   = NW'(p1_r) + NW'(p2_r);
    anum  = num[NW-1] ? NW'(-num) : NW'(num);
    aden  = den_r[XW-1] ? XW'(-den_r) : XW'(den_r);
    n_nxt = (anum << 1) + NW'(aden);
    d_nxt = {aden, 1'b0};
    info_nxt.touch = touch_r;
    info_nxt.horiz = horiz_r;
    info_nxt.neg   = num[NW-1] ^ den_r[XW-1];
    info_nxt.hlo   = hlo_r;
    info_nxt.hhi   = hhi_r;
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    info_r <= info_nxt;
  end

  assign n_o    = n_r;
  assign d_o    = d_r;
  assign info_o = info_r;

endmodule

// ----- design/tss_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on tss_pkg
module tss_div (
  input  logic                   clk,
  input  logic [tss_pkg::NW-1:0] n_i,
  input  logic [tss_pkg::DW-1:0] d_i,
  output logic [tss_pkg::QB-1:0] q_o
);
  import tss_pkg::*;

  logic [NW-1:0] rem_r [QB];
  logic [DW-1:0] dd_r  [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QB-1:0] q_in;
    logic [NW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = n_i;
      assign d_in   = d_i;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign d_in   = dd_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      trial = {1'b0, rem_in} - ((NW+1)'(d_in) << (QB - 1 - k));
      take  = !trial[NW];
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= take ? trial[NW-1:0] : rem_in;
      dd_r[k]  <= d_in;
      q_r[k]   <= {q_in[QB-2:0], take};
    end
  end

  assign q_o = q_r[QB-1];

endmodule

// ----- design/tss_span.sv -----
// span merge, clip and address generation, four register stages
// depends on tss_pkg
module tss_span (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  tss_pkg::coord_t                    y_i,
  input  logic [15:0]                        color_i,
  input  logic [2:0][tss_pkg::QB-1:0]        q_i,
  input  tss_pkg::edge_info_t [2:0]          info_i,
  input  tss_pkg::clip_cfg_t                 cfg_i,
  output logic                               strobe_o,
  output tss_pkg::out_item_t                 data_o
);
  import tss_pkg::*;

  // stage a: per edge extent
  logic        va_r;
  coord_t      ya_r;
  logic [15:0] cola_r;
  logic [2:0]  eh_r;
  xval_t       elo_r [3];
  xval_t       ehi_r [3];
  xval_t       qs    [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      qs[e] = info_i[e].neg ? -XW'(q_i[e]) : XW'(q_i[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= valid_i;
    end
    ya_r   <= y_i;
    cola_r <= color_i;
    for (int e = 0; e < 3; e++) begin
      eh_r[e]  <= info_i[e].touch;
      elo_r[e] <= info_i[e].horiz ? info_i[e].hlo : qs[e];
      ehi_r[e] <= info_i[e].horiz ? info_i[e].hhi : qs[e];
    end
  end

  // stage b: merge the per edge extents
  logic        vb_r, have_nxt, have_r;
  coord_t      yb_r;
  logic [15:0] colb_r;
  xval_t       lo_nxt, hi_nxt, lo_r, hi_r;

  always_comb begin
    have_nxt = 1'b0;
    lo_nxt   = '0;
    hi_nxt   = '0;
    for (int e = 0; e < 3; e++) begin
      if (eh_r[e]) begin
        if (!have_nxt || elo_r[e] < lo_nxt) lo_nxt = elo_r[e];
        if (!have_nxt || ehi_r[e] > hi_nxt) hi_nxt = ehi_r[e];
        have_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    yb_r   <= ya_r;
    colb_r <= cola_r;
    have_r <= have_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
  end

  // stage c: clip and row stride product
  logic signed [SW-1:0] lo_e, hi1_e, ye, cl, ct, cr, cb, x0, x1, cnt;
  logic                 ok_nxt;
  logic [CFG_W-1:0]     yu;
  logic                 vc_r, okc_r;
  logic [CFG_W-1:0]     x0_r, yu_r;
  logic [10:0]          cnt_r;
  logic [2*CFG_W-1:0]   prod_r;
  logic [15:0]          colc_r;

  always_comb begin
    lo_e   = SW'(lo_r);
    hi1_e  = SW'(hi_r) + SW'(1);
    ye     = SW'(yb_r);
    cl     = $signed(SW'(cfg_i.clip_left));
    ct     = $signed(SW'(cfg_i.clip_top));
    cr     = $signed(SW'(cfg_i.clip_right));
    cb     = $signed(SW'(cfg_i.clip_bottom));
    x0     = (lo_e > cl) ? lo_e : cl;
    x1     = (hi1_e < cr) ? hi1_e : cr;
    cnt    = x1 - x0;
    ok_nxt = have_r && (x0 < x1) && (ye >= ct) && (ye < cb);
    yu     = ye[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    okc_r  <= ok_nxt;
    x0_r   <= x0[CFG_W-1:0];
    yu_r   <= yu;
    cnt_r  <= cnt[10:0];
    prod_r <= yu * cfg_i.canvas_width;
    colc_r <= colb_r;
  end

  // stage d: byte address and output register
  logic [19:0] pix;
  out_item_t   data_nxt, data_r;
  logic        strobe_r;

  always_comb begin
    pix                   = prod_r[19:0] + 20'(x0_r);
    data_nxt.span_valid   = okc_r;
    data_nxt.span_row     = okc_r ? yu_r[9:0] : '0;
    data_nxt.first_column = okc_r ? x0_r[9:0] : '0;
    data_nxt.pixel_count  = okc_r ? cnt_r : '0;
    data_nxt.byte_address = okc_r ? {pix, 1'b0} : '0;
    data_nxt.color_out    = colc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vc_r;
    end
    data_r <= data_nxt;
  end

  assign strobe_o = strobe_r;
  assign data_o   = data_r;

endmodule

// ----- design/triangle_scanline_span.sv -----
// top level of the triangle scanline span block
// depends on tss_pkg, tss_edge, tss_div and tss_span
//
// one span per triangle row: a beat is taken on start whenever busy is low.
// busy is high during reset and for the first cycle after it, and low from
// then on, so a new beat may follow in each clock. the result beat appears
// on out_strobe after the input register, the edge setup, divider and span
// stages, one result per accepted beat, in order; the receiver cannot hold
// it off. the three parallel edge dividers resolve one quotient bit per
// stage. configuration writes (cfg_ready is high whenever reset is
// released) must be made while no beat is in flight.
module triangle_scanline_span (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  tss_pkg::in_item_t          in_data,
  output logic                       out_strobe,
  output tss_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tss_pkg::IDX_W-1:0]  cfg_index,
  input  logic [tss_pkg::CFG_W-1:0]  cfg_data
);
  import tss_pkg::*;

  // busy is held high in reset and for the first cycle out of reset
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy      = busy_r | !rst_n;
  assign cfg_ready = rst_n;

  // clip and stride registers
  clip_cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left    <= CFG_W'(0);
      cfg_r.clip_top     <= CFG_W'(0);
      cfg_r.clip_right   <= CFG_W'(128);
      cfg_r.clip_bottom  <= CFG_W'(128);
      cfg_r.canvas_width <= CFG_W'(128);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLIP_LEFT:    cfg_r.clip_left    <= cfg_data;
        REG_CLIP_TOP:     cfg_r.clip_top     <= cfg_data;
        REG_CLIP_RIGHT:   cfg_r.clip_right   <= cfg_data;
        REG_CLIP_BOTTOM:  cfg_r.clip_bottom  <= cfg_data;
        REG_CANVAS_WIDTH: cfg_r.canvas_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic     v0_r;
  in_item_t in_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy_r;
    end
    in_r <= in_data;
  end

  // edge setup: a-b, b-c, c-a
  logic [2:0][NW-1:0] n_w;
  logic [2:0][DW-1:0] d_w;
  edge_info_t [2:0]   info_w;
  logic [2:0][QB-1:0] q_w;

  tss_edge u_edge_ab (
    .clk(clk), .ex0(in_r.ax), .ey0(in_r.ay), .ex1(in_r.bx), .ey1(in_r.by),
    .y(in_r.row), .n_o(n_w[0]), .d_o(d_w[0]), .info_o(info_w[0])
  );
  tss_edge u_edge_bc (
    .clk(clk), .ex0(in_r.bx), .ey0(in_r.by), .ex1(in_r.cx), .ey1(in_r.cy),
    .y(in_r.row), .n_o(n_w[1]), .d_o(d_w[1]), .info_o(info_w[1])
  );
  tss_edge u_edge_ca (
    .clk(clk), .ex0(in_r.cx), .ey0(in_r.cy), .ex1(in_r.ax), .ey1(in_r.ay),
    .y(in_r.row), .n_o(n_w[2]), .d_o(d_w[2]), .info_o(info_w[2])
  );

  // one divider per edge gives the rounded crossing magnitude
  for (genvar e = 0; e < 3; e++) begin : g_div
    tss_div u_div (.clk(clk), .n_i(n_w[e]), .d_i(d_w[e]), .q_o(q_w[e]));
  end

  // edge flags ride alongside the divider stages
  edge_info_t [2:0] info_dl_r [QB];
  always_ff @(posedge clk) begin
    info_dl_r[0] <= info_w;
    for (int k = 1; k < QB; k++) begin
      info_dl_r[k] <= info_dl_r[k-1];
    end
  end

  // row, colour and valid bit follow through setup and divide
  localparam int SIDE_D = SETUP_LAT + QB;
  side_t side_r [SIDE_D];
  side_t side_in;
  always_comb begin
    side_in.valid = v0_r;
    side_in.row   = in_r.row;
    side_in.color = in_r.color_in;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SIDE_D; k++) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else begin
        side_r[k].valid <= (k == 0) ? side_in.valid : side_r[(k == 0) ? 0 : k-1].valid;
      end
      side_r[k].row   <= (k == 0) ? side_in.row   : side_r[(k == 0) ? 0 : k-1].row;
      side_r[k].color <= (k == 0) ? side_in.color : side_r[(k == 0) ? 0 : k-1].color;
    end
  end

  // merge, clip and address
  tss_span u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (side_r[SIDE_D-1].valid),
    .y_i      (side_r[SIDE_D-1].row),
    .color_i  (side_r[SIDE_D-1].color),
    .q_i      (q_w),
    .info_i   (info_dl_r[QB-1]),
    .cfg_i    (cfg_r),
    .strobe_o (out_strobe),
    .data_o   (out_data)
  );

endmodule

// ----- design/tss_checker.sv -----
// port-level checks for the triangle scanline span block, bound to the top
// depends on tss_pkg and triangle_scanline_span_assert.svh
`include "triangle_scanline_span_assert.svh"

module tss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input tss_pkg::in_item_t          in_data,
  input logic                       out_strobe,
  input tss_pkg::out_item_t         out_data,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [tss_pkg::IDX_W-1:0]  cfg_index,
  input logic [tss_pkg::CFG_W-1:0]  cfg_data
);
  import tss_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // every accepted beat yields its result a fixed time later
  `TSS_ASSERT_IMP(a_result_follows, acc, ##LATENCY out_strobe)
  // no result without a beat taken the fixed time before
  `TSS_ASSERT_IMP(a_no_spurious, out_strobe, $past(acc, LATENCY))
  // an empty span reports zero geometry
  `TSS_ASSERT_IMP(a_empty_zero, out_strobe && !out_data.span_valid,
    out_data.pixel_count == '0 && out_data.byte_address == '0 &&
    out_data.first_column == '0 && out_data.span_row == '0)
  // a drawn span covers at least one pixel
  `TSS_ASSERT_NEVER(a_valid_nonempty,
    out_strobe && out_data.span_valid && out_data.pixel_count == '0)

endmodule

bind triangle_scanline_span tss_checker u_tss_checker (.*);

// ----- bench/tb_triangle_scanline_span.sv -----
// self-checking bench for the triangle scanline span block
// depends on tss_pkg and triangle_scanline_span; drives beats, predicts spans, compares
`timescale 1ns / 1ps

module tb_triangle_scanline_span;
  import tss_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  triangle_scanline_span u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // bench copy of the clip rectangle and stride
  clip_cfg_t   clip_shadow;
  out_item_t   span_queue[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;

  // one directed row: the expected span is typed in only when flagged
  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t span;
  } span_case_t;

  // ----------------------------------------------------------------------
  // span predictor
  // ----------------------------------------------------------------------

  // n/d to nearest, halves away from zero
  function automatic longint round_half_away(longint n, longint d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  // widen the span by one edge crossing of the row
  function automatic void add_edge(longint x_a, longint y_a, longint x_b, longint y_b,
                                   longint y, inout bit hit, inout longint lo,
                                   inout longint hi);
    longint xs[2];
    int     n;
    longint dy;
    n = 0;
    if ((y < y_a && y < y_b) || (y > y_a && y > y_b)) return;
    if (y_a == y_b) begin
      // edge lies on the row: both ends count
      xs[0] = x_a;
      xs[1] = x_b;
      n = 2;
    end else begin
      dy    = y_b - y_a;
      xs[0] = round_half_away(x_a * dy + (x_b - x_a) * (y - y_a), dy);
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (!hit || xs[i] < lo) lo = xs[i];
      if (!hit || xs[i] > hi) hi = xs[i];
      hit = 1'b1;
    end
  endfunction

  function automatic out_item_t predict_span(in_item_t b, clip_cfg_t c);
    out_item_t r;
    bit        hit;
    longint    lo, hi, x0, x1, y, addr;
    longint    ax, ay, bx, by, cx, cy;
    hit = 1'b0;
    lo  = 0;
    hi  = 0;
    ax  = $signed(b.ax);
    ay  = $signed(b.ay);
    bx  = $signed(b.bx);
    by  = $signed(b.by);
    cx  = $signed(b.cx);
    cy  = $signed(b.cy);
    y   = $signed(b.row);
    add_edge(ax, ay, bx, by, y, hit, lo, hi);
    add_edge(bx, by, cx, cy, y, hit, lo, hi);
    add_edge(cx, cy, ax, ay, y, hit, lo, hi);
    x0 = (lo > longint'(c.clip_left)) ? lo : longint'(c.clip_left);
    x1 = ((hi + 1) < longint'(c.clip_right)) ? (hi + 1) : longint'(c.clip_right);
    r = '0;
    if (hit && x0 < x1 && y >= longint'(c.clip_top) && y < longint'(c.clip_bottom)) begin
      addr           = (y * longint'(c.canvas_width) + x0) * 2;
      r.span_valid   = 1'b1;
      r.span_row     = y[9:0];
      r.first_column = x0[9:0];
      r.pixel_count  = 11'(x1 - x0);
      r.byte_address = addr[20:0];
    end
    r.color_out = b.color_in;
    return r;
  endfunction

  // ----------------------------------------------------------------------
  // result checker: every strobe must match the oldest expectation
  // ----------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (span_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected span beat %p", out_data);
      end else begin
        out_item_t want;
        want = span_queue.pop_front();
        if (out_data.span_valid   !== want.span_valid   ||
            out_data.span_row     !== want.span_row     ||
            out_data.first_column !== want.first_column ||
            out_data.pixel_count  !== want.pixel_count  ||
            out_data.byte_address !== want.byte_address ||
            out_data.color_out    !== want.color_out) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("span mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // watchdog: cycles where no beat moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ----------------------------------------------------------------------
  // stimulus helpers
  // ----------------------------------------------------------------------

  // one input beat after a random idle gap; start stays high across back-to-back beats
  task automatic send_triangle(in_item_t b, bit typed, out_item_t span);
    int gap;
    gap = (($urandom_range(3) == 0)) ? 0 : $urandom_range(6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    span_queue.insert(span_queue.size(), typed ? span : predict_span(b, clip_shadow));
  endtask

  // stop sending and wait until every span has come back
  task automatic drain_spans();
    start <= 1'b0;
    @(posedge clk);
    while (span_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CLIP_LEFT:    clip_shadow.clip_left    = val;
      REG_CLIP_TOP:     clip_shadow.clip_top     = val;
      REG_CLIP_RIGHT:   clip_shadow.clip_right   = val;
      REG_CLIP_BOTTOM:  clip_shadow.clip_bottom  = val;
      REG_CANVAS_WIDTH: clip_shadow.canvas_width = val;
      default: ;
    endcase
  endtask

  task automatic write_clip(int l, int t, int r, int b, int w);
    write_reg(REG_CLIP_LEFT,    CFG_W'(l));
    write_reg(REG_CLIP_TOP,     CFG_W'(t));
    write_reg(REG_CLIP_RIGHT,   CFG_W'(r));
    write_reg(REG_CLIP_BOTTOM,  CFG_W'(b));
    write_reg(REG_CANVAS_WIDTH, CFG_W'(w));
  endtask

  function automatic coord_t pick_coord(int lo, int hi);
    return coord_t'(lo + int'($urandom_range(hi - lo)));
  endfunction

  // random triangle: mostly near the clip window, row inside its y range
  function automatic in_item_t random_triangle();
    in_item_t b;
    int       ymin, ymax, hi_lim;
    b.color_in = 16'($urandom);
    if ($urandom_range(9) < 2) begin
      // anywhere in the coordinate space
      b.ax  = coord_t'($urandom);
      b.ay  = coord_t'($urandom);
      b.bx  = coord_t'($urandom);
      b.by  = coord_t'($urandom);
      b.cx  = coord_t'($urandom);
      b.cy  = coord_t'($urandom);
      b.row = coord_t'($urandom);
    end else begin
      hi_lim = ($urandom_range(1)) ? 160 : 1100;
      b.ax = pick_coord(-40, hi_lim);
      b.ay = pick_coord(-40, hi_lim);
      b.bx = pick_coord(-40, hi_lim);
      // flat edges now and then
      b.by = ($urandom_range(4) == 0) ? b.ay : pick_coord(-40, hi_lim);
      b.cx = pick_coord(-40, hi_lim);
      b.cy = pick_coord(-40, hi_lim);
      ymin = $signed(b.ay);
      ymax = $signed(b.ay);
      if ($signed(b.by) < ymin) ymin = $signed(b.by);
      if ($signed(b.cy) < ymin) ymin = $signed(b.cy);
      if ($signed(b.by) > ymax) ymax = $signed(b.by);
      if ($signed(b.cy) > ymax) ymax = $signed(b.cy);
      b.row = ($urandom_range(7) == 0) ? pick_coord(-40, hi_lim) : pick_coord(ymin, ymax);
    end
    return b;
  endfunction

  // ----------------------------------------------------------------------
  // directed table, run under reset settings (clip 0..128, width 128)
  // ----------------------------------------------------------------------
  function automatic in_item_t tri_beat(int ax, int ay, int bx, int by, int cx, int cy,
                                        int row, int col);
    in_item_t b;
    b.ax = coord_t'(ax);
    b.ay = coord_t'(ay);
    b.bx = coord_t'(bx);
    b.by = coord_t'(by);
    b.cx = coord_t'(cx);
    b.cy = coord_t'(cy);
    b.row = coord_t'(row);
    b.color_in = 16'(col);
    return b;
  endfunction

  function automatic out_item_t blank_span(int col);
    out_item_t r;
    r = '0;
    r.color_out = 16'(col);
    return r;
  endfunction

  span_case_t directed[$];

  task automatic build_directed();
    span_case_t c;
    out_item_t  s;
    // flat top edge on the row: columns 0..10
    s = '0;
    s.span_valid = 1'b1;
    s.pixel_count = 11'd11;
    s.color_out = 16'hF800;
    c = '{tri_beat(0, 0, 10, 0, 0, 10, 0, 16'hF800), 1'b1, s};
    directed.insert(directed.size(), c);
    // row past the triangle: nothing touches
    c = '{tri_beat(0, 0, 10, 0, 0, 10, 20, 16'h07E0), 1'b1, blank_span(16'h07E0)};
    directed.insert(directed.size(), c);
    // row above the clip window
    c = '{tri_beat(0, -5, 10, -5, 0, 10, -1, 16'hFFFF), 1'b1, blank_span(16'hFFFF)};
    directed.insert(directed.size(), c);
    // coordinate extremes
    c = '{tri_beat(-2048, -2048, 2047, 2047, -2048, 2047, 0, 0), 1'b1, blank_span(0)};
    c.typed = 1'b0;
    directed.insert(directed.size(), c);
    c = '{tri_beat(2047, -2048, -2048, 2047, 2047, 2047, 64, 16'hFFFF), 1'b0, s};
    directed.insert(directed.size(), c);
    c = '{tri_beat(-2048, 0, 2047, 0, 0, 100, 0, 16'h1234), 1'b0, s};
    directed.insert(directed.size(), c);
    // halves in both directions: crossings at 0.5, -0.5, 8.5 and 25.5
    c = '{tri_beat(0, 0, 1, 2, 50, 0, 1, 16'h0001), 1'b0, s};
    directed.insert(directed.size(), c);
    c = '{tri_beat(0, 0, -1, 2, 50, 2, 1, 16'h0002), 1'b0, s};
    directed.insert(directed.size(), c);
    c = '{tri_beat(10, 0, 7, 2, 30, 4, 1, 16'h0003), 1'b0, s};
    directed.insert(directed.size(), c);
    // span beyond the right clip
    c = '{tri_beat(-50, 10, 300, 10, 100, 90, 40, 16'hABCD), 1'b0, s};
    directed.insert(directed.size(), c);
    // degenerate point and vertical line
    c = '{tri_beat(5, 5, 5, 5, 5, 5, 5, 16'h5555), 1'b0, s};
    directed.insert(directed.size(), c);
    c = '{tri_beat(7, 0, 7, 20, 7, 10, 10, 16'hAAAA), 1'b0, s};
    directed.insert(directed.size(), c);
    // last clip row and first row outside
    c = '{tri_beat(0, 0, 127, 127, 0, 200, 127, 16'h00FF), 1'b0, s};
    directed.insert(directed.size(), c);
    c = '{tri_beat(0, 0, 127, 127, 0, 200, 128, 16'hFF00), 1'b0, s};
    directed.insert(directed.size(), c);
  endtask

  // ----------------------------------------------------------------------
  // main sequence
  // ----------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_cycles = 0;
    mismatch_count = 0;
    clip_shadow = '{clip_left: 0, clip_top: 0, clip_right: 128, clip_bottom: 128,
                    canvas_width: 128};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (directed[i])
      send_triangle(directed[i].beat, directed[i].typed, directed[i].span);
    for (int i = 0; i < 200; i++)
      send_triangle(random_triangle(), 1'b0, '0);
    drain_spans();

    // settings walk: extremes first, then random rectangles
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_clip(0, 0, 1024, 1024, 1024);
        1: write_clip(0, 0, 0, 0, 1);
        2: write_clip(2047, 2047, 2047, 2047, 2047);
        3: write_clip(20, 10, 100, 90, 0);
        4: write_clip(1024, 0, 1024, 1024, 64);
        default: write_clip($urandom_range(120), $urandom_range(120),
                            $urandom_range(1024), $urandom_range(1024),
                            $urandom_range(1, 1024));
      endcase
      for (int i = 0; i < 215; i++)
        send_triangle(random_triangle(), 1'b0, '0);
      drain_spans();
    end

    // let the pipeline settle before the verdict
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && span_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
